>>> rtl/core/tnkl_pkg.sv
// Package for the tempo normalized knock lock.
// Holds payload structs, mode, phase and register codes and default parameters; no dependencies.
package tnkl_pkg;
    localparam int CODE_DEPTH_DEF = 64;
    localparam int CAL_CYCLES_DEF = 3;

    localparam logic [1:0] MODE_ON     = 2'd0;
    localparam logic [1:0] MODE_OFF    = 2'd1;
    localparam logic [1:0] MODE_BUTTON = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_MEAS_ON  = 3'd1;
    localparam logic [2:0] PH_MEAS_OFF = 3'd2;
    localparam logic [2:0] PH_WAIT     = 3'd3;
    localparam logic [2:0] PH_PRESSED  = 3'd4;
    localparam logic [2:0] PH_RELEASED = 3'd5;

    localparam logic [1:0] REG_LENIENCY = 2'd0;
    localparam logic [1:0] REG_TEMPO    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_us;
    } tnkl_in_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       unlocked;
        logic       failed;
        logic       setting_code;
        logic [6:0] tap_index;
    } tnkl_out_t;
endpackage

>>> rtl/core/tempo_normalized_knock_lock.sv
// Top level of the tempo normalized knock lock.
// Uses tnkl_pkg and tnkl_ram (code store).
//
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    tnkl_in_t  (mode, now_us)
// m_       out        m_valid/m_ready    tnkl_out_t (phase .. tap_index)
// apb      in         psel/penable       leniency, tempo unit, record timeout
//
// A touch duration after calibration needs two products, then two 72-bit restoring
// divisions at one bit a cycle, in S_MUL1 to S_MUL3, S_DIVQ and S_DIVL, before S_DEC.
// Other items go from S_DEC to S_OUT, passing S_END when they end a sequence.
// The store read is registered. Reset is synchronous; the store needs no clearing.
// A result waiting in the output register stalls only the final step of the next item.
module tempo_normalized_knock_lock #(
    parameter int CODE_DEPTH = tnkl_pkg::CODE_DEPTH_DEF,
    parameter int CAL_CYCLES = tnkl_pkg::CAL_CYCLES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tnkl_pkg::tnkl_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tnkl_pkg::tnkl_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tnkl_pkg::*;

    localparam int AW = $clog2(CODE_DEPTH);
    localparam int PW = AW + 1;
    localparam int DW = 72;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_DIVQ = 4'd4;
    localparam logic [3:0] S_DIVL = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_END  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [31:0] leniency_reg, timeout_reg;
    logic [23:0] tempo_reg;
    logic [2:0]  phase_reg;
    logic        record_reg;
    logic [PW-1:0] pos_reg;
    logic [2:0]  calib_reg;
    logic [34:0] on_tot_reg, off_tot_reg;
    logic [31:0] last_reg;
    logic [3:0]  st_reg;
    tnkl_in_t    item_reg;
    logic        unl_reg, fail_reg;
    logic [34:0] den_reg;
    logic [31:0] delta_reg;
    logic [31:0] scale_reg;
    logic [DW-1:0] num_reg, rem_reg, quo_reg, lim_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] t_reg;
    logic        mv_reg;
    tnkl_out_t   out_reg;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    tnkl_ram #(.WIDTH(32), .DEPTH(CODE_DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign pready  = 1'b1;
    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_comb begin
        unique case (paddr[3:2])
            REG_LENIENCY: prdata = leniency_reg;
            REG_TEMPO:    prdata = {8'd0, tempo_reg};
            REG_TIMEOUT:  prdata = timeout_reg;
            default:      prdata = 32'd0;
        endcase
    end

    logic [31:0] delta_w;
    logic [DW-1:0] trial;
    logic [31:0] diff;
    logic [PW-1:0] pos_inc;
    logic [63:0] num_prod, lim_prod;
    logic        div_take;
    logic [DW-1:0] div_rem, div_quo;
    logic        dur_hit, term_hit, pos_ok, out_load;
    assign delta_w = item_reg.now_us - last_reg;
    assign trial   = {rem_reg[DW-2:0], num_reg[DW-1]};
    assign diff    = (t_reg > ram_rdata) ? t_reg - ram_rdata : ram_rdata - t_reg;
    assign pos_inc = pos_reg + PW'(1);
    assign ram_addr = pos_reg[AW-1:0];
    assign num_prod = delta_reg * scale_reg;
    assign lim_prod = leniency_reg * scale_reg;
    assign div_take = trial >= DW'(den_reg);
    assign div_rem  = div_take ? trial - DW'(den_reg) : trial;
    assign div_quo  = {num_reg[DW-2:0], div_take};
    assign dur_hit  = (phase_reg == PH_PRESSED && item_reg.mode == MODE_OFF) ||
                      (phase_reg == PH_RELEASED && item_reg.mode == MODE_ON);
    assign term_hit = phase_reg == PH_RELEASED && item_reg.mode == MODE_TICK &&
                      record_reg && delta_w >= timeout_reg;
    assign pos_ok   = pos_reg < PW'(CODE_DEPTH);
    assign out_load = (st_reg == S_OUT) && (!mv_reg || m_ready);

    assign ram_we    = (st_reg == S_DEC) && record_reg && pos_ok && (dur_hit || term_hit);
    assign ram_wdata = term_hit ? 32'd0 : t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leniency_reg <= 32'd1000000;
            tempo_reg    <= 24'd1000000;
            timeout_reg  <= 32'd3000000;
            phase_reg    <= PH_IDLE;
            record_reg   <= 1'b1;
            pos_reg      <= '0;
            calib_reg    <= '0;
            on_tot_reg   <= '0;
            off_tot_reg  <= '0;
            last_reg     <= '0;
            st_reg       <= S_IDLE;
            mv_reg       <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_LENIENCY: leniency_reg <= pwdata;
                    REG_TEMPO:    tempo_reg <= pwdata[23:0];
                    REG_TIMEOUT:  timeout_reg <= pwdata;
                    default: ;
                endcase
            end
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg <= s_data;
                        unl_reg  <= 1'b0;
                        fail_reg <= 1'b0;
                        if ((phase_reg == PH_PRESSED && s_data.mode == MODE_OFF) ||
                            (phase_reg == PH_RELEASED && s_data.mode == MODE_ON)) begin
                            st_reg <= S_MUL1;
                        end else begin
                            st_reg <= S_DEC;
                        end
                    end
                end
                S_MUL1: begin
                    delta_reg <= delta_w;
                    last_reg  <= item_reg.now_us;
                    scale_reg <= 32'(tempo_reg) * 32'(CAL_CYCLES);
                    den_reg   <= (phase_reg == PH_PRESSED) ?
                                 ((on_tot_reg == '0) ? 35'd1 : on_tot_reg) :
                                 ((off_tot_reg == '0) ? 35'd1 : off_tot_reg);
                    st_reg <= S_MUL2;
                end
                S_MUL2: begin
                    num_reg <= DW'(num_prod);
                    lim_reg <= DW'(lim_prod);
                    st_reg  <= S_MUL3;
                end
                S_MUL3: begin
                    lim_reg <= lim_reg + DW'(den_reg) - DW'(1);
                    rem_reg <= '0;
                    cnt_reg <= 7'(DW);
                    st_reg  <= S_DIVQ;
                end
                S_DIVQ, S_DIVL: begin
                    if (cnt_reg == 7'd1) begin
                        rem_reg <= '0;
                        cnt_reg <= 7'(DW);
                        if (st_reg == S_DIVQ) begin
                            quo_reg <= div_quo;
                            num_reg <= lim_reg;
                            st_reg  <= S_DIVL;
                        end else begin
                            lim_reg <= div_quo;
                            t_reg   <= (quo_reg[DW-1:32] != '0) ? 32'hFFFFFFFF : quo_reg[31:0];
                            st_reg  <= S_DEC;
                        end
                    end else begin
                        rem_reg <= div_rem;
                        num_reg <= div_quo;
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_DEC: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (item_reg.mode == MODE_BUTTON) begin
                                record_reg <= 1'b1;
                            end else if (item_reg.mode == MODE_ON) begin
                                last_reg  <= item_reg.now_us;
                                phase_reg <= PH_MEAS_ON;
                            end
                            st_reg <= S_OUT;
                        end
                        PH_MEAS_ON: begin
                            if (item_reg.mode == MODE_OFF) begin
                                on_tot_reg <= on_tot_reg + 35'(delta_w);
                                last_reg   <= item_reg.now_us;
                                phase_reg  <= PH_MEAS_OFF;
                            end
                            st_reg <= S_OUT;
                        end
                        PH_MEAS_OFF: begin
                            if (item_reg.mode == MODE_ON) begin
                                off_tot_reg <= off_tot_reg + 35'(delta_w);
                                last_reg    <= item_reg.now_us;
                                if (4'(calib_reg) + 4'd1 >= 4'(CAL_CYCLES)) begin
                                    calib_reg <= '0;
                                    phase_reg <= PH_WAIT;
                                end else begin
                                    calib_reg <= calib_reg + 3'd1;
                                    phase_reg <= PH_MEAS_ON;
                                end
                            end
                            st_reg <= S_OUT;
                        end
                        PH_WAIT: begin
                            if (item_reg.mode == MODE_ON) begin
                                last_reg  <= item_reg.now_us;
                                phase_reg <= PH_PRESSED;
                            end
                            st_reg <= S_OUT;
                        end
                        PH_PRESSED, PH_RELEASED: begin
                            if (dur_hit) begin
                                if (!pos_ok) begin
                                    fail_reg <= 1'b1;
                                    st_reg   <= S_END;
                                end else if (record_reg) begin
                                    pos_reg   <= pos_inc;
                                    phase_reg <= (phase_reg == PH_PRESSED) ?
                                                 PH_RELEASED : PH_PRESSED;
                                    st_reg    <= S_OUT;
                                end else begin
                                    st_reg <= S_CMP;
                                end
                            end else if (term_hit) begin
                                if (pos_ok) begin
                                    unl_reg <= 1'b1;
                                end else begin
                                    fail_reg <= 1'b1;
                                end
                                st_reg <= S_END;
                            end else begin
                                st_reg <= S_OUT;
                            end
                        end
                        default: st_reg <= S_END;
                    endcase
                end
                S_CMP: begin
                    if (ram_rdata == 32'd0) begin
                        unl_reg <= 1'b1;
                        st_reg  <= S_END;
                    end else if (DW'(diff) < lim_reg) begin
                        pos_reg   <= pos_inc;
                        phase_reg <= (phase_reg == PH_PRESSED) ? PH_RELEASED : PH_PRESSED;
                        st_reg    <= S_OUT;
                    end else begin
                        fail_reg <= 1'b1;
                        st_reg   <= S_END;
                    end
                end
                S_END: begin
                    phase_reg   <= PH_IDLE;
                    record_reg  <= 1'b0;
                    pos_reg     <= '0;
                    calib_reg   <= '0;
                    on_tot_reg  <= '0;
                    off_tot_reg <= '0;
                    st_reg      <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        out_reg.phase        <= phase_reg;
                        out_reg.unlocked     <= unl_reg;
                        out_reg.failed       <= fail_reg;
                        out_reg.setting_code <= record_reg;
                        out_reg.tap_index    <= 7'(pos_reg);
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/tnkl_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module tnkl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
